// ===== src/moore_automaton_row_step_macros.svh =====
// Assertion macros shared by the row-step RTL.
`ifndef MOORE_AUTOMATON_ROW_STEP_MACROS_SVH
`define MOORE_AUTOMATON_ROW_STEP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define MARS_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define MARS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mars_pkg.sv =====
// Package with the types, constants and helpers of the automaton row step.
`timescale 1ns / 1ps

package mars_pkg;

   localparam int CELL_BITS   = 64;
   localparam int ROW_CELLS   = 64;
   localparam int WIDTH_BITS  = 7;
   localparam int THRESH_BITS = 4;
   localparam int COUNT_BITS  = 4;

   // Register indexes; register i sits at byte address 4*i.
   localparam logic [1:0] REG_ROW_WIDTH     = 2'd0;
   localparam logic [1:0] REG_SURVIVE_MIN   = 2'd1;
   localparam logic [1:0] REG_BIRTH_ABOVE   = 2'd2;
   localparam logic [1:0] REG_INVERT_OUTPUT = 2'd3;

   typedef struct packed {
      logic [CELL_BITS-1:0] cells_in;
      logic                 frame_end;
   } req_type;

   typedef struct packed {
      logic [CELL_BITS-1:0] cells_out;
      logic                 frame_end_out;
   } rsp_type;

   // Rule settings broadcast to every lane.
   typedef struct packed {
      logic [THRESH_BITS-1:0] survive_min;
      logic [THRESH_BITS-1:0] birth_above;
      logic                   invert_output;
   } rule_type;

   // Bit 0 is the left neighbor column, bit 1 the cell column, bit 2 the right one.
   typedef struct packed {
      logic [2:0] up;
      logic [2:0] mid;
      logic [2:0] down;
   } nbr_type;

   // Results caused by one accepted row: one or two output beats.
   typedef struct packed {
      logic [CELL_BITS-1:0] row0;
      logic [CELL_BITS-1:0] row1;
      logic                 two;
      logic                 last0;
   } pair_type;

   // Columns below the effective width are inside the frame.
   function automatic logic [CELL_BITS-1:0] valid_mask(input logic [WIDTH_BITS-1:0] width);
      logic [WIDTH_BITS-1:0] eff;
      logic [CELL_BITS-1:0]  mask;
      eff = (width > WIDTH_BITS'(ROW_CELLS)) ? WIDTH_BITS'(ROW_CELLS) : width;
      for (int x = 0; x < CELL_BITS; x++) begin
         mask[x] = (WIDTH_BITS'(x) < eff);
      end
      return mask;
   endfunction

endpackage

// ===== src/mars_lane.sv =====
// One cell lane: counts the eight neighbors and applies the survive and birth rule.
`timescale 1ns / 1ps

module mars_lane
   import mars_pkg::*;
(
   input  nbr_type  nbr,
   input  rule_type rule,
   output logic     next_cell
);

   logic [COUNT_BITS-1:0] count;
   logic                  alive;
   logic                  next_raw;

   assign count = COUNT_BITS'(nbr.up[0]) + COUNT_BITS'(nbr.up[1]) + COUNT_BITS'(nbr.up[2])
                + COUNT_BITS'(nbr.mid[0]) + COUNT_BITS'(nbr.mid[2])
                + COUNT_BITS'(nbr.down[0]) + COUNT_BITS'(nbr.down[1])
                + COUNT_BITS'(nbr.down[2]);

   assign alive     = nbr.mid[1];
   assign next_raw  = alive ? (count >= rule.survive_min) : (count > rule.birth_above);
   assign next_cell = next_raw ^ rule.invert_output;

endmodule

// ===== src/mars_gen.sv =====
// One generation of a row: a lane per column, then a merge that masks the frame width.
`timescale 1ns / 1ps

module mars_gen
   import mars_pkg::*;
(
   input  logic [CELL_BITS-1:0] row_up,
   input  logic [CELL_BITS-1:0] row_mid,
   input  logic [CELL_BITS-1:0] row_down,
   input  rule_type             rule,
   input  logic [CELL_BITS-1:0] mask,
   output logic [CELL_BITS-1:0] row_next
);

   // Each row gets an alive column on both sides for the frame edges.
   logic [CELL_BITS+1:0] ext_up;
   logic [CELL_BITS+1:0] ext_mid;
   logic [CELL_BITS+1:0] ext_down;
   logic [CELL_BITS-1:0] lane_out;

   assign ext_up   = {1'b1, row_up,   1'b1};
   assign ext_mid  = {1'b1, row_mid,  1'b1};
   assign ext_down = {1'b1, row_down, 1'b1};

   for (genvar x = 0; x < CELL_BITS; x++) begin : g_lane
      nbr_type nbr;
      assign nbr.up   = ext_up[x+2:x];
      assign nbr.mid  = ext_mid[x+2:x];
      assign nbr.down = ext_down[x+2:x];

      mars_lane u_lane (
         .nbr       (nbr),
         .rule      (rule),
         .next_cell (lane_out[x])
      );
   end

   assign row_next = lane_out & mask;

endmodule

// ===== src/moore_automaton_row_step.sv =====
// A result beat is registered into the result queue when the row that causes it is accepted.
// Rows are taken one per cycle while the two-entry result queue is not full; a frame-end row
// that follows a held row gives two beats, and its queue entry is popped once both are out.
// All 64 cells are evaluated by parallel lanes; two generation units cover both beats.
// Reset (synchronous): registers return to width 64, thresholds 4, no invert, empty frame.
`timescale 1ns / 1ps

module moore_automaton_row_step
   import mars_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

`include "moore_automaton_row_step_macros.svh"

   localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH   = WIDTH_BITS'(64);
   localparam logic [THRESH_BITS-1:0] RESET_SURVIVE = THRESH_BITS'(4);
   localparam logic [THRESH_BITS-1:0] RESET_BIRTH   = THRESH_BITS'(4);
   localparam logic [1:0]             QUEUE_FULL    = 2'd2;

   // Configuration registers.
   logic [WIDTH_BITS-1:0]  row_width_ff, row_width_in;
   logic [THRESH_BITS-1:0] survive_ff, survive_in;
   logic [THRESH_BITS-1:0] birth_ff, birth_in;
   logic                   invert_ff, invert_in;
   logic [CELL_BITS-1:0]   mask_ff, mask_in;

   // Row history.
   logic [CELL_BITS-1:0]   above_ff, above_in;
   logic [CELL_BITS-1:0]   middle_ff, middle_in;
   logic                   mid_valid_ff, mid_valid_in;

   // Result queue: q0 is the head.
   pair_type               q0_ff, q0_in;
   pair_type               q1_ff, q1_in;
   logic [1:0]             cnt_ff, cnt_in;
   logic                   sel_ff, sel_in;

   logic                   csr_write;
   logic [1:0]             csr_index;
   logic                   in_fire;
   logic                   out_fire;
   logic                   pop;
   logic                   push;
   logic                   last;
   logic [1:0]             cnt_mid;
   logic [CELL_BITS-1:0]   row_pad;
   logic [CELL_BITS-1:0]   gen_a_up;
   logic [CELL_BITS-1:0]   gen_a_mid;
   logic [CELL_BITS-1:0]   gen_a_down;
   logic [CELL_BITS-1:0]   gen_a_row;
   logic [CELL_BITS-1:0]   gen_b_row;
   rule_type               rule;
   pair_type               new_pair;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      row_width_in = row_width_ff;
      survive_in   = survive_ff;
      birth_in     = birth_ff;
      invert_in    = invert_ff;
      mask_in      = mask_ff;
      if (csr_write) begin
         case (csr_index)
            REG_ROW_WIDTH: begin
               row_width_in = csr_pwdata[WIDTH_BITS-1:0];
               mask_in      = valid_mask(csr_pwdata[WIDTH_BITS-1:0]);
            end
            REG_SURVIVE_MIN:   survive_in = csr_pwdata[THRESH_BITS-1:0];
            REG_BIRTH_ABOVE:   birth_in   = csr_pwdata[THRESH_BITS-1:0];
            REG_INVERT_OUTPUT: invert_in  = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ROW_WIDTH:     csr_prdata = 32'(row_width_ff);
         REG_SURVIVE_MIN:   csr_prdata = 32'(survive_ff);
         REG_BIRTH_ABOVE:   csr_prdata = 32'(birth_ff);
         REG_INVERT_OUTPUT: csr_prdata = 32'(invert_ff);
         default:           csr_prdata = 32'd0;
      endcase
   end

   assign rule.survive_min   = survive_ff;
   assign rule.birth_above   = birth_ff;
   assign rule.invert_output = invert_ff;

   // ---------------- row evaluation ----------------
   assign in_fire = req_valid && !req_stall;
   assign last    = req_data.frame_end;
   assign row_pad = (req_data.cells_in & mask_ff) | ~mask_ff;

   // Without a held row the incoming row is evaluated alone between outside rows.
   assign gen_a_up   = mid_valid_ff ? above_ff  : '1;
   assign gen_a_mid  = mid_valid_ff ? middle_ff : row_pad;
   assign gen_a_down = mid_valid_ff ? row_pad   : '1;

   mars_gen u_gen_a (
      .row_up   (gen_a_up),
      .row_mid  (gen_a_mid),
      .row_down (gen_a_down),
      .rule     (rule),
      .mask     (mask_ff),
      .row_next (gen_a_row)
   );

   // The closing row of a frame, used only for the second beat.
   mars_gen u_gen_b (
      .row_up   (middle_ff),
      .row_mid  (row_pad),
      .row_down ('1),
      .rule     (rule),
      .mask     (mask_ff),
      .row_next (gen_b_row)
   );

   always_comb begin
      above_in     = above_ff;
      middle_in    = middle_ff;
      mid_valid_in = mid_valid_ff;
      if (in_fire) begin
         if (last) begin
            above_in     = '1;
            mid_valid_in = 1'b0;
         end else if (mid_valid_ff) begin
            above_in  = middle_ff;
            middle_in = row_pad;
         end else begin
            above_in     = '1;
            middle_in    = row_pad;
            mid_valid_in = 1'b1;
         end
      end
   end

   // ---------------- result queue ----------------
   assign new_pair.row0  = gen_a_row;
   assign new_pair.row1  = gen_b_row;
   assign new_pair.two   = mid_valid_ff && last;
   assign new_pair.last0 = !mid_valid_ff;

   assign rsp_valid              = (cnt_ff != 2'd0);
   assign rsp_data.cells_out     = sel_ff ? q0_ff.row1 : q0_ff.row0;
   assign rsp_data.frame_end_out = sel_ff || q0_ff.last0;
   assign req_stall              = (cnt_ff == QUEUE_FULL);

   assign out_fire = rsp_valid && !rsp_stall;
   assign pop      = out_fire && (!q0_ff.two || sel_ff);
   assign push     = in_fire && (last || mid_valid_ff);
   assign cnt_mid  = cnt_ff - {1'b0, pop};

   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      sel_in = sel_ff;
      if (out_fire) begin
         sel_in = !pop;
      end
      if (pop) begin
         q0_in = q1_ff;
      end
      if (push) begin
         if (cnt_mid == 2'd0) begin
            q0_in = new_pair;
         end else begin
            q1_in = new_pair;
         end
      end
      cnt_in = cnt_mid + {1'b0, push};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= RESET_WIDTH;
         survive_ff   <= RESET_SURVIVE;
         birth_ff     <= RESET_BIRTH;
         invert_ff    <= 1'b0;
         mask_ff      <= valid_mask(RESET_WIDTH);
         above_ff     <= '1;
         mid_valid_ff <= 1'b0;
         cnt_ff       <= 2'd0;
         sel_ff       <= 1'b0;
      end else begin
         row_width_ff <= row_width_in;
         survive_ff   <= survive_in;
         birth_ff     <= birth_in;
         invert_ff    <= invert_in;
         mask_ff      <= mask_in;
         above_ff     <= above_in;
         mid_valid_ff <= mid_valid_in;
         cnt_ff       <= cnt_in;
         sel_ff       <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      middle_ff <= middle_in;
      q0_ff     <= q0_in;
      q1_ff     <= q1_in;
   end

   // ---------------- assertions ----------------
   `MARS_ASSERT_NEXT(a_frame_end_clears, in_fire && last,
                     !mid_valid_ff && (above_ff == '1), "frame end did not clear row history")
   `MARS_ASSERT_NEXT(a_second_beat, out_fire && q0_ff.two && !sel_ff,
                     sel_ff && rsp_valid, "second beat of a frame end was lost")
   `MARS_ASSERT_NOW(a_sel_needs_head, sel_ff, (cnt_ff != 2'd0) && q0_ff.two,
                    "second-beat select without a two-beat head")
   `MARS_ASSERT_NOW(a_second_is_last, rsp_valid && sel_ff, rsp_data.frame_end_out,
                    "second beat not marked as frame end")

endmodule

// ===== test/tb_moore_automaton_row_step.sv =====
// Self-checking testbench for the row-streaming Moore-neighborhood automaton step.
`timescale 1ns / 1ps

module tb_moore_automaton_row_step
   import mars_pkg::*;
();

   localparam logic [CELL_BITS-1:0] ALL_ALIVE = '1;
   localparam int RANDOM_ROWS  = 1850;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct {
      bit                   is_cfg;
      logic [1:0]           index;
      logic [31:0]          value;
      logic [CELL_BITS-1:0] cells;
      logic                 last;
      bit                   typed;
      logic [CELL_BITS-1:0] typed_cells;
   } plan_step_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Typed-in result for the row currently offered, travels beside req_data.
   bit                   req_typed = 1'b0;
   logic [CELL_BITS-1:0] req_typed_cells = '0;

   // Predictor copy of the configuration and the row window.
   logic [WIDTH_BITS-1:0]  cfg_width;
   logic [THRESH_BITS-1:0] cfg_survive;
   logic [THRESH_BITS-1:0] cfg_birth;
   logic                   cfg_invert;
   logic [CELL_BITS-1:0]   above_row;
   logic [CELL_BITS-1:0]   middle_row;
   logic                   middle_held;

   rsp_type       pending_rows[$];
   plan_step_type plan[$];

   int failures = 0;
   int beats_checked = 0;
   int rows_sent = 0;
   int frames_sent = 0;
   int single_row_frames = 0;
   int register_writes = 0;
   int send_calm = 0;
   bit hold_request = 1'b0;
   bit hold_taken = 1'b0;

   moore_automaton_row_step DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles with %0d beats still owed", CYCLE_LIMIT,
               pending_rows.size());
      $display("** moore_automaton_row_step: FAILED **");
      $finish;
   end

   function automatic logic [CELL_BITS-1:0] width_mask();
      logic [CELL_BITS-1:0] m;
      int eff;
      eff = (int'(cfg_width) > ROW_CELLS) ? ROW_CELLS : int'(cfg_width);
      for (int x = 0; x < CELL_BITS; x++) begin
         m[x] = (x < eff);
      end
      return m;
   endfunction

   function automatic logic [CELL_BITS-1:0] evolve_row(input logic [CELL_BITS-1:0] up,
                                                      input logic [CELL_BITS-1:0] mid,
                                                      input logic [CELL_BITS-1:0] down);
      logic [CELL_BITS+1:0] ext [0:2];
      logic [CELL_BITS-1:0] res;
      int count;
      logic next_alive;
      // The one-bit pads on either side stand for the alive columns off the frame.
      ext[0] = {1'b1, up, 1'b1};
      ext[1] = {1'b1, mid, 1'b1};
      ext[2] = {1'b1, down, 1'b1};
      for (int x = 0; x < CELL_BITS; x++) begin
         count = 0;
         for (int k = 0; k < 3; k++) begin
            count += int'(ext[k][x]) + int'(ext[k][x+2]);
            if (k != 1) count += int'(ext[k][x+1]);
         end
         if (mid[x]) next_alive = (count >= int'(cfg_survive));
         else next_alive = (count > int'(cfg_birth));
         res[x] = next_alive ^ cfg_invert;
      end
      return res & width_mask();
   endfunction

   task automatic predict_row(input req_type item, input bit typed,
                              input logic [CELL_BITS-1:0] typed_cells);
      logic [CELL_BITS-1:0] row;
      rsp_type beat;
      row = (item.cells_in & width_mask()) | ~width_mask();
      if (!middle_held) begin
         if (item.frame_end) begin
            beat.cells_out = typed ? typed_cells : evolve_row(ALL_ALIVE, row, ALL_ALIVE);
            beat.frame_end_out = 1'b1;
            pending_rows.push_back(beat);
            middle_row = '0;
         end else begin
            middle_row = row;
            middle_held = 1'b1;
         end
         above_row = ALL_ALIVE;
      end else begin
         beat.cells_out = evolve_row(above_row, middle_row, row);
         beat.frame_end_out = 1'b0;
         pending_rows.push_back(beat);
         above_row = middle_row;
         middle_row = row;
         if (item.frame_end) begin
            beat.cells_out = evolve_row(above_row, middle_row, ALL_ALIVE);
            beat.frame_end_out = 1'b1;
            pending_rows.push_back(beat);
            above_row = ALL_ALIVE;
            middle_row = '0;
            middle_held = 1'b0;
         end
      end
   endtask

   task automatic report_failure(input string msg);
      failures++;
      if (failures <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic check_beat(input rsp_type got);
      rsp_type want;
      beats_checked++;
      if (pending_rows.size() == 0) begin
         report_failure($sformatf("beat %0d with nothing owed: cells_out %h frame_end_out %b",
                                  beats_checked, got.cells_out, got.frame_end_out));
      end else begin
         want = pending_rows.pop_front();
         if (got.cells_out !== want.cells_out || got.frame_end_out !== want.frame_end_out) begin
            report_failure($sformatf(
               "beat %0d: cells_out exp %h got %h, frame_end_out exp %b got %b",
               beats_checked, want.cells_out, got.cells_out,
               want.frame_end_out, got.frame_end_out));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_width   = WIDTH_BITS'(ROW_CELLS);
         cfg_survive = THRESH_BITS'(4);
         cfg_birth   = THRESH_BITS'(4);
         cfg_invert  = 1'b0;
         above_row   = ALL_ALIVE;
         middle_row  = '0;
         middle_held = 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_ROW_WIDTH:     cfg_width   = csr_pwdata[WIDTH_BITS-1:0];
               REG_SURVIVE_MIN:   cfg_survive = csr_pwdata[THRESH_BITS-1:0];
               REG_BIRTH_ABOVE:   cfg_birth   = csr_pwdata[THRESH_BITS-1:0];
               REG_INVERT_OUTPUT: cfg_invert  = csr_pwdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_row(req_data, req_typed, req_typed_cells);
         if (rsp_valid && !rsp_stall) check_beat(rsp_data);
      end
   end

   // Receiver: short stalls, occasional long ones, calm stretches and one long hold-off.
   initial begin
      int burst_left;
      int calm_left;
      int r;
      burst_left = 0;
      calm_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            burst_left = HOLD_CYCLES;
            calm_left = 0;
         end
         if (burst_left == 0 && calm_left == 0) begin
            r = $urandom_range(0, 99);
            if (r < 60) calm_left = $urandom_range(1, 8);
            else if (r < 90) burst_left = $urandom_range(1, 3);
            else if (r < 97) burst_left = $urandom_range(10, 30);
            else calm_left = $urandom_range(50, 150);
         end
         if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else begin
            calm_left--;
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) begin
         send_calm = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(8, 30);
   endfunction

   task automatic send_row(input logic [CELL_BITS-1:0] cells, input logic last,
                           input bit typed, input logic [CELL_BITS-1:0] typed_cells);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.cells_in <= cells;
      req_data.frame_end <= last;
      req_typed <= typed;
      req_typed_cells <= typed_cells;
      do @(posedge clock); while (req_stall);
      rows_sent++;
   endtask

   // The block is idle once every owed beat is out and a further DRAIN_CYCLES wait has passed.
   task automatic settle_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [31:0] value);
      settle_idle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      register_writes++;
   endtask

   task automatic plan_cfg(input logic [1:0] index, input logic [31:0] value);
      plan.push_back('{1'b1, index, value, '0, 1'b0, 1'b0, '0});
   endtask

   task automatic plan_row(input logic [CELL_BITS-1:0] cells, input logic last);
      plan.push_back('{1'b0, REG_ROW_WIDTH, '0, cells, last, 1'b0, '0});
   endtask

   // A single-row frame whose result can be read off by hand.
   task automatic plan_typed(input logic [CELL_BITS-1:0] cells,
                             input logic [CELL_BITS-1:0] result);
      plan.push_back('{1'b0, REG_ROW_WIDTH, '0, cells, 1'b1, 1'b1, result});
   endtask

   function automatic logic [CELL_BITS-1:0] random_row();
      logic [CELL_BITS-1:0] a;
      logic [CELL_BITS-1:0] b;
      a = {$urandom, $urandom};
      b = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: return '0;
         1: return ALL_ALIVE;
         2: return a & b & {$urandom, $urandom};
         3: return a | b;
         4: return CELL_BITS'(1) << $urandom_range(0, CELL_BITS - 1);
         default: return a;
      endcase
   endfunction

   function automatic logic [31:0] pick_width();
      logic [WIDTH_BITS-1:0] width_extremes [8] = '{0, 1, 2, 3, 63, 64, 65, 127};
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) return 32'(width_extremes[$urandom_range(0, 7)]);
      if (r < 25) return $urandom_range(0, 127);
      return $urandom_range(1, 64);
   endfunction

   function automatic logic [31:0] pick_threshold(input bit for_birth);
      logic [THRESH_BITS-1:0] survive_extremes [4] = '{0, 8, 9, 15};
      logic [THRESH_BITS-1:0] birth_extremes [4] = '{0, 7, 8, 15};
      int r;
      r = $urandom_range(0, 99);
      if (r < 20) begin
         return for_birth ? 32'(birth_extremes[$urandom_range(0, 3)])
                          : 32'(survive_extremes[$urandom_range(0, 3)]);
      end
      if (r < 30) return $urandom_range(0, 15);
      return $urandom_range(1, 6);
   endfunction

   task automatic send_frame(input int length);
      for (int i = 0; i < length; i++) begin
         send_row(random_row(), (i == length - 1), 1'b0, '0);
      end
      frames_sent++;
      if (length == 1) single_row_frames++;
   endtask

   initial begin
      int random_rows;
      int r;
      int length;

      // Reset configuration: uniform rows, then a three-row frame.
      plan_typed(ALL_ALIVE, ALL_ALIVE);
      plan_typed('0, ALL_ALIVE);
      plan_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
      plan_row(64'h5555_5555_5555_5555, 1'b0);
      plan_row(64'h0123_4567_89AB_CDEF, 1'b1);
      // Thresholds past the neighbor count: nothing lives, nothing is born.
      plan_cfg(REG_SURVIVE_MIN, 32'd9);
      plan_cfg(REG_BIRTH_ABOVE, 32'd8);
      plan_typed(ALL_ALIVE, '0);
      plan_typed('0, '0);
      plan_cfg(REG_INVERT_OUTPUT, 32'd1);
      plan_typed(64'hDEAD_BEEF_0BAD_F00D, ALL_ALIVE);
      plan_cfg(REG_SURVIVE_MIN, 32'd0);
      plan_cfg(REG_BIRTH_ABOVE, 32'd0);
      plan_cfg(REG_INVERT_OUTPUT, 32'd0);
      plan_row('0, 1'b0);
      plan_row(64'h0000_0001_0000_0000, 1'b0);
      plan_row('0, 1'b1);
      // A one-column frame sees only alive padding around its dead cell.
      plan_cfg(REG_ROW_WIDTH, 32'd1);
      plan_typed('0, 64'h1);
      // With no valid column every output bit is clear.
      plan_cfg(REG_ROW_WIDTH, 32'd0);
      plan_typed(ALL_ALIVE, '0);
      plan_row(64'h1234, 1'b0);
      plan_row(64'h5678, 1'b1);
      plan_cfg(REG_ROW_WIDTH, 32'd127);
      plan_cfg(REG_SURVIVE_MIN, 32'd15);
      plan_cfg(REG_BIRTH_ABOVE, 32'd15);
      plan_row(64'hFFFF_0000_FFFF_0000, 1'b0);
      plan_row(64'h0F0F_0F0F_0F0F_0F0F, 1'b1);
      plan_cfg(REG_ROW_WIDTH, 32'd3);
      plan_cfg(REG_SURVIVE_MIN, 32'd3);
      plan_cfg(REG_BIRTH_ABOVE, 32'd2);
      plan_cfg(REG_INVERT_OUTPUT, 32'd1);
      plan_row(64'h5, 1'b0);
      plan_row(64'hFFFF_FFFF_FFFF_FFF2, 1'b0);
      plan_row(64'h7, 1'b1);
      plan_cfg(REG_ROW_WIDTH, 32'd64);
      plan_cfg(REG_SURVIVE_MIN, 32'd2);
      plan_cfg(REG_BIRTH_ABOVE, 32'd3);
      plan_cfg(REG_INVERT_OUTPUT, 32'd0);
      plan_row('0, 1'b0);
      plan_row(64'h0000_0070_0000_0000, 1'b0);
      plan_row(64'h8000_0000_0000_0001, 1'b1);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            write_register(plan[i].index, plan[i].value);
         end else begin
            send_row(plan[i].cells, plan[i].last, plan[i].typed, plan[i].typed_cells);
            if (plan[i].last) frames_sent++;
         end
      end

      random_rows = 0;
      while (random_rows < RANDOM_ROWS) begin
         write_register(REG_ROW_WIDTH, pick_width());
         write_register(REG_SURVIVE_MIN, pick_threshold(1'b0));
         write_register(REG_BIRTH_ABOVE, pick_threshold(1'b1));
         write_register(REG_INVERT_OUTPUT, $urandom_range(0, 1));
         repeat ($urandom_range(2, 12)) begin
            r = $urandom_range(0, 99);
            if (r < 20) length = 1;
            else if (r < 80) length = $urandom_range(2, 6);
            else if (r < 95) length = $urandom_range(7, 20);
            else length = $urandom_range(40, 64);
            // Starve the result side once the run is under way while a long frame keeps coming.
            if (random_rows > 300 && !hold_request) begin
               hold_request = 1'b1;
               length = 64;
            end
            send_frame(length);
            random_rows += length;
         end
      end

      settle_idle();
      repeat (10) @(posedge clock);

      $display("Ran %0d rows in %0d frames (%0d single-row), checked %0d result beats,",
               rows_sent, frames_sent, single_row_frames, beats_checked);
      $display("with %0d register writes and a %0d-cycle result hold-off; %0d failures.",
               register_writes, HOLD_CYCLES, failures);
      if (failures == 0) begin
         $display("** moore_automaton_row_step: PASSED **");
      end else begin
         $display("** moore_automaton_row_step: FAILED **");
      end
      $finish;
   end

endmodule
